// ===== hw/rtl/mch_pkg.sv =====
// Shared types, constants and tables for the magnetometer calibration and heading block.
package mch_pkg;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int BR_W    = 16;
    localparam int OFS_W   = 18;
    localparam int GAIN_W  = 16;
    localparam int FLUX_W  = 22;
    localparam int HEAD_W  = 12;

    // APB register port
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef logic        [RAW_W-1:0]  t_raw;
    typedef logic signed [BR_W-1:0]   t_bridge;
    typedef logic signed [OFS_W-1:0]  t_offset;
    typedef logic        [GAIN_W-1:0] t_gain;
    typedef logic signed [FLUX_W-1:0] t_flux;
    typedef logic        [HEAD_W-1:0] t_heading;

    typedef enum logic [1:0] {
        FUNC_NORMAL = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_RESET  = 2'd2
    } t_func;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Y   = 3'd4,
        REG_GAIN_Z   = 3'd5
    } t_reg;

    localparam t_gain GAIN_UNITY = 16'd10000;
    localparam t_raw  CENTER     = 16'd32767;

    // raw -> counts scaling: * 10000 / 4096
    localparam logic signed [15:0] SCALE_NUM = 16'sd10000;
    localparam int SCALE_SHIFT = 12;
    localparam int SCALE_DEN   = 1 << SCALE_SHIFT;

    // gain divide by 10000 = shift by 4, then divide by 625 via reciprocal
    localparam int GAIN_DIV_SHIFT = 4;
    localparam int GAIN_DIV_ODD   = 625;
    localparam int RECIP_SHIFT    = 40;
    localparam int RECIP_W        = 31;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'((64'd1 << RECIP_SHIFT) / GAIN_DIV_ODD);

    localparam int LANE_DEPTH = 7;

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TAB_LEN      = 24;
    localparam int TAB_W        = 5;
    localparam int ATAN_W       = 25;
    localparam int VEC_SHIFT    = 24;
    localparam int ANGLE_FRAC   = 16;
    localparam int XW           = FLUX_W + VEC_SHIFT + 3;
    localparam int ZW           = 30;
    localparam int HW           = ZW - ANGLE_FRAC;

    localparam int HEAD_QUARTER = 900;
    localparam int HEAD_HALF    = 1800;
    localparam int HEAD_3Q      = 2700;
    localparam int HEAD_FULL    = 3600;
    localparam int HEAD_MAX     = HEAD_FULL - 1;

    // atan(2^-i) in tenths of a degree, 16 fractional bits
    localparam logic [ATAN_W-1:0] ATAN_TAB [TAB_LEN] = '{
        25'd29491200, 25'd17409672, 25'd9198793, 25'd4669451,
        25'd2343786,  25'd1173036,  25'd586661,  25'd293348,
        25'd146676,   25'd73339,    25'd36669,   25'd18335,
        25'd9167,     25'd4584,     25'd2292,    25'd1146,
        25'd573,      25'd286,      25'd143,     25'd72,
        25'd36,       25'd18,       25'd9,       25'd4
    };

endpackage

// ===== hw/rtl/mch_sample_if.sv =====
// Input channel: one raw three-axis sample with its kind tag.
interface mch_sample_if;
    import mch_pkg::*;

    logic  valid;
    logic  ready;
    logic  [1:0] func;
    t_raw  raw_x;
    t_raw  raw_y;
    t_raw  raw_z;

    modport source (output valid, func, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, func, raw_x, raw_y, raw_z, output ready);
endinterface

// ===== hw/rtl/mch_result_if.sv =====
// Output channel: calibrated flux on three axes and the compass heading.
interface mch_result_if;
    import mch_pkg::*;

    logic     valid;
    logic     ready;
    t_flux    flux_x;
    t_flux    flux_y;
    t_flux    flux_z;
    t_heading heading_tenths;

    modport source (output valid, flux_x, flux_y, flux_z, heading_tenths, input ready);
    modport sink   (input valid, flux_x, flux_y, flux_z, heading_tenths, output ready);
endinterface

// ===== hw/rtl/mch_axis_lane.sv =====
// One axis lane: centre, bridge offset, scale, user offset and gain, saturate.
module mch_axis_lane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mch_pkg::t_raw    i_raw,
    input  mch_pkg::t_bridge i_bridge,
    input  mch_pkg::t_offset i_offset,
    input  mch_pkg::t_gain   i_gain,
    output logic            o_done,
    output mch_pkg::t_flux   o_flux
);
    import mch_pkg::*;

    localparam int V_W   = RAW_W + 2;
    localparam int PV_W  = 32;
    localparam int T_W   = 19;
    localparam int D_W   = 20;
    localparam int P_W   = 36;
    localparam int A_W   = 31;
    localparam int MUL_W = A_W + RECIP_W;
    localparam int S_W   = FLUX_W + 1;
    localparam logic signed [S_W-1:0] SAT_HI = S_W'((1 << (FLUX_W - 1)) - 1);
    localparam logic signed [S_W-1:0] SAT_LO = -SAT_HI - S_W'(1);

    logic [LANE_DEPTH-1:0] r_vld;

    logic signed [V_W-1:0]  v;
    logic signed [PV_W-1:0] pv;
    logic signed [PV_W-1:0] r_pv;
    logic signed [PV_W-1:0] pv_bias;
    logic signed [PV_W-1:0] pv_adj;
    logic signed [T_W-1:0]  t;
    logic signed [D_W-1:0]  d;
    logic signed [D_W-1:0]  r_d;
    logic signed [P_W-1:0]  p;
    logic signed [P_W-1:0]  r_p;
    logic        [P_W-1:0]  mag;
    logic        [A_W-1:0]  r_a4;
    logic                   r_neg4;
    logic        [MUL_W-1:0] m;
    logic        [FLUX_W-1:0] r_q0;
    logic        [A_W-1:0]  r_a5;
    logic                   r_neg5;
    logic        [A_W-1:0]  prod;
    logic        [A_W-1:0]  rem;
    logic        [FLUX_W-1:0] r_q;
    logic                   r_neg6;
    logic signed [S_W-1:0]  sv;
    logic signed [S_W-1:0]  sat;
    t_flux                  r_flux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_DEPTH-2:0], i_start};
        end
    end

    // stage 1: centre, remove bridge offset, * 10000
    assign v  = signed'(V_W'(i_raw)) - signed'(V_W'(CENTER)) - V_W'(i_bridge);
    assign pv = PV_W'(v) * PV_W'(SCALE_NUM);

    // stage 2: / 4096 toward zero, minus user offset
    assign pv_bias = r_pv[PV_W-1] ? PV_W'(SCALE_DEN - 1) : '0;
    assign pv_adj  = r_pv + pv_bias;
    assign t       = pv_adj[SCALE_SHIFT+T_W-1:SCALE_SHIFT];
    assign d       = D_W'(t) - D_W'(i_offset);

    // stage 3: gain product
    assign p = P_W'(r_d) * P_W'(signed'({1'b0, i_gain}));

    // stage 4: magnitude, / 16
    assign mag = r_p[P_W-1] ? P_W'(-r_p) : P_W'(r_p);

    // stage 5: / 625 by reciprocal, may come out one low
    assign m = MUL_W'(r_a4) * MUL_W'(RECIP_MUL);

    // stage 6: one correction step
    assign prod = A_W'(r_q0) * A_W'(GAIN_DIV_ODD);
    assign rem  = r_a5 - prod;

    // stage 7: sign back on, saturate
    assign sv  = r_neg6 ? -S_W'({1'b0, r_q}) : S_W'({1'b0, r_q});
    assign sat = (sv > SAT_HI) ? SAT_HI : ((sv < SAT_LO) ? SAT_LO : sv);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pv <= pv;
        end
        if (r_vld[0]) begin
            r_d <= d;
        end
        if (r_vld[1]) begin
            r_p <= p;
        end
        if (r_vld[2]) begin
            r_a4   <= mag[A_W+GAIN_DIV_SHIFT-1:GAIN_DIV_SHIFT];
            r_neg4 <= r_p[P_W-1];
        end
        if (r_vld[3]) begin
            r_q0   <= m[RECIP_SHIFT+FLUX_W-1:RECIP_SHIFT];
            r_a5   <= r_a4;
            r_neg5 <= r_neg4;
        end
        if (r_vld[4]) begin
            r_q    <= r_q0 + FLUX_W'(rem >= A_W'(GAIN_DIV_ODD));
            r_neg6 <= r_neg5;
        end
        if (r_vld[5]) begin
            r_flux <= FLUX_W'(sat);
        end
    end

    assign o_done = r_vld[LANE_DEPTH-1];
    assign o_flux = r_flux;

endmodule

// ===== hw/rtl/mch_cordic.sv =====
// Merge stage: heading from x and y flux by an iterative vectoring CORDIC.
module mch_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mch_pkg::t_flux    i_fx,
    input  mch_pkg::t_flux    i_fy,
    output logic             o_done,
    output mch_pkg::t_heading o_heading
);
    import mch_pkg::*;

    localparam logic signed [ZW-1:0] HALF_Z = ZW'(HEAD_HALF * (1 << ANGLE_FRAC));

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} t_cstate;

    t_cstate              r_state;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    t_heading             r_heading;

    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;
    logic                 left;
    logic signed [XW-1:0] x_ld;
    logic signed [XW-1:0] y_ld;
    logic signed [ZW-1:0] z_ld;
    logic                 axis_hit;
    t_heading             axis_head;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] tab;
    logic signed [XW-1:0] x_nx;
    logic signed [XW-1:0] y_nx;
    logic signed [ZW-1:0] z_nx;
    logic                 last;

    logic signed [ZW-1:0] z_adj;
    logic signed [HW-1:0] h_trunc;
    logic signed [HW-1:0] h_wrap;
    t_heading             z_head;

    // load: fold left half plane onto the right one
    assign x_ext = XW'(i_fx) <<< VEC_SHIFT;
    assign y_ext = XW'(i_fy) <<< VEC_SHIFT;
    assign left  = i_fx[FLUX_W-1];
    assign x_ld  = left ? -x_ext : x_ext;
    assign y_ld  = left ? -y_ext : y_ext;
    assign z_ld  = !left ? '0 : (i_fy[FLUX_W-1] ? -HALF_Z : HALF_Z);

    always_comb begin
        axis_hit  = (i_fy == '0) || (i_fx == '0);
        axis_head = '0;
        if (i_fy == '0) begin
            axis_head = left ? HEAD_W'(HEAD_HALF) : '0;
        end else if (i_fx == '0) begin
            axis_head = i_fy[FLUX_W-1] ? HEAD_W'(HEAD_3Q) : HEAD_W'(HEAD_QUARTER);
        end
    end

    // one micro-rotation
    assign dx   = r_y >>> r_step;
    assign dy   = r_x >>> r_step;
    assign tab  = ZW'(signed'({1'b0, ATAN_TAB[TAB_W'(r_step)]}));
    assign x_nx = r_y[XW-1] ? (r_x - dx)  : (r_x + dx);
    assign y_nx = r_y[XW-1] ? (r_y + dy)  : (r_y - dy);
    assign z_nx = r_y[XW-1] ? (r_z - tab) : (r_z + tab);
    assign last = (r_step == STEP_W'(CORDIC_STEPS - 1));

    // angle to tenths, toward zero, then wrap negatives
    assign z_adj   = r_z + (r_z[ZW-1] ? ZW'((1 << ANGLE_FRAC) - 1) : '0);
    assign h_trunc = z_adj[ZW-1:ANGLE_FRAC];

    always_comb begin
        h_wrap = h_trunc[HW-1] ? (h_trunc + HW'(HEAD_FULL)) : h_trunc;
        if (h_wrap[HW-1]) begin
            z_head = '0;
        end else if (h_wrap > HW'(HEAD_MAX)) begin
            z_head = HEAD_W'(HEAD_MAX);
        end else begin
            z_head = HEAD_W'(h_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                C_IDLE: begin
                    r_done <= i_start && axis_hit;
                    if (i_start) begin
                        r_step <= '0;
                        if (axis_hit) begin
                            r_heading <= axis_head;
                        end else begin
                            r_state <= C_RUN;
                        end
                    end
                end
                C_RUN: begin
                    r_done <= 1'b0;
                    r_step <= r_step + STEP_W'(1);
                    if (last) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    r_heading <= z_head;
                    r_done    <= 1'b1;
                    r_state   <= C_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_x <= x_ld;
            r_y <= y_ld;
            r_z <= z_ld;
        end else if (r_state == C_RUN) begin
            r_x <= x_nx;
            r_y <= y_nx;
            r_z <= z_nx;
        end
    end

    assign o_done    = r_done;
    assign o_heading = r_heading;

endmodule

// ===== hw/rtl/magnetometer_calibrate_heading.sv =====
// Magnetometer calibration and compass heading, top level.
//
// Takes one raw three-axis sample per request, tagged as a set-pulse sample, a
// reset-pulse sample or a normal measurement. Set samples are stored and reset
// samples update the bridge offsets in the cycle they are accepted; neither
// produces a result, and the block is ready again on the next cycle. A normal
// sample runs through three identical axis lanes in parallel (centre, bridge
// offset, *10000/4096, user offset, gain/10000, saturation to 22 bits), a
// seven-stage pipeline, and the merge stage then works the heading in tenths of
// a degree (0..3599) from x and y with an iterative vectoring CORDIC, one
// micro-rotation a cycle over CORDIC_STEPS (16) steps. The result register is
// loaded when the CORDIC is done, and the block goes back to idle as it is
// loaded. When y or x is zero the heading is decided directly, with no
// micro-rotations. A finished result sits in its own register, so a new request
// is accepted while it waits to be taken; only if a second result is ready
// before the first has gone does the block hold off. Registers (APB, 32-bit
// data, at 4*i): offsets x/y/z at 0x00, 0x04, 0x08 (18-bit signed, reset 0),
// gains x/y/z at 0x0C, 0x10, 0x14 (16-bit, 10000 is unity, reset 10000). Write
// them only while the block is idle.
module magnetometer_calibrate_heading (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mch_sample_if.sink                    i_sample,
    mch_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mch_pkg::PADDR_W-1:0]   paddr,
    input  logic [mch_pkg::PDATA_W-1:0]   pwdata,
    output logic [mch_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import mch_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LANE, S_ANGLE, S_HOLD} t_state;

    t_state  r_state;

    // configuration
    t_offset r_offset [3];
    t_gain   r_gain   [3];

    // set-pulse samples and bridge offsets
    t_bridge r_set    [3];
    t_bridge r_bridge [3];

    // output register
    logic     r_out_valid;
    t_flux    r_flux_x;
    t_flux    r_flux_y;
    t_flux    r_flux_z;
    t_heading r_heading;

    logic                 in_acc;
    logic                 lane_start;
    logic [2:0]           lane_done_v;
    logic                 lane_done;
    t_flux                flux [3];
    logic                 cordic_start;
    logic                 cordic_done;
    t_heading             cordic_head;
    logic                 out_free;
    logic                 out_take;
    logic                 load_out;
    logic [REG_IDX_W-1:0] reg_idx;
    t_raw                 raw [3];
    t_bridge              cent [3];
    t_bridge              avg [3];
    logic signed [BR_W:0] sum [3];
    logic signed [BR_W:0] sum_adj [3];

    assign raw[0] = i_sample.raw_x;
    assign raw[1] = i_sample.raw_y;
    assign raw[2] = i_sample.raw_z;

    assign i_sample.ready = (r_state == S_IDLE);
    assign in_acc         = i_sample.valid && i_sample.ready;
    assign lane_start     = in_acc && (i_sample.func == FUNC_NORMAL);

    // ---------------------------------------------------------------
    // APB register file; pready tied high, no wait states
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_offset[a] <= '0;
                r_gain[a]   <= GAIN_UNITY;
            end
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_OFFSET_X: r_offset[0] <= pwdata[OFS_W-1:0];
                REG_OFFSET_Y: r_offset[1] <= pwdata[OFS_W-1:0];
                REG_OFFSET_Z: r_offset[2] <= pwdata[OFS_W-1:0];
                REG_GAIN_X:   r_gain[0]   <= pwdata[GAIN_W-1:0];
                REG_GAIN_Y:   r_gain[1]   <= pwdata[GAIN_W-1:0];
                REG_GAIN_Z:   r_gain[2]   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OFFSET_X: prdata = PDATA_W'(r_offset[0]);
            REG_OFFSET_Y: prdata = PDATA_W'(r_offset[1]);
            REG_OFFSET_Z: prdata = PDATA_W'(r_offset[2]);
            REG_GAIN_X:   prdata = PDATA_W'(r_gain[0]);
            REG_GAIN_Y:   prdata = PDATA_W'(r_gain[1]);
            REG_GAIN_Z:   prdata = PDATA_W'(r_gain[2]);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Set/reset pulse handling. Centring wraps to 16 bits; the mean of the
    // set and reset samples is truncated toward zero.
    // ---------------------------------------------------------------
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cent[a]    = signed'(raw[a] - CENTER);
            sum[a]     = (BR_W + 1)'(r_set[a]) + (BR_W + 1)'(cent[a]);
            sum_adj[a] = sum[a] + (BR_W + 1)'(sum[a][BR_W]);
            avg[a]     = sum_adj[a][BR_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_set[a]    <= '0;
                r_bridge[a] <= '0;
            end
        end else if (in_acc) begin
            case (i_sample.func)
                FUNC_SET: begin
                    for (int a = 0; a < 3; a++) begin
                        r_set[a] <= cent[a];
                    end
                end
                FUNC_RESET: begin
                    for (int a = 0; a < 3; a++) begin
                        r_bridge[a] <= avg[a];
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Axis lanes, all three in lock step
    // ---------------------------------------------------------------
    for (genvar g = 0; g < 3; g++) begin : g_lane
        mch_axis_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (lane_start),
            .i_raw    (raw[g]),
            .i_bridge (r_bridge[g]),
            .i_offset (r_offset[g]),
            .i_gain   (r_gain[g]),
            .o_done   (lane_done_v[g]),
            .o_flux   (flux[g])
        );
    end

    assign lane_done = &lane_done_v;

    // ---------------------------------------------------------------
    // Heading from saturated x and y
    // ---------------------------------------------------------------
    assign cordic_start = (r_state == S_LANE) && lane_done;

    mch_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cordic_start),
        .i_fx      (flux[0]),
        .i_fy      (flux[1]),
        .o_done    (cordic_done),
        .o_heading (cordic_head)
    );

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    assign out_take = r_out_valid && o_result.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign load_out = out_free &&
                      (((r_state == S_ANGLE) && cordic_done) || (r_state == S_HOLD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_flux_x    <= flux[0];
                r_flux_y    <= flux[1];
                r_flux_z    <= flux[2];
                r_heading   <= cordic_head;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (lane_start) begin
                        r_state <= S_LANE;
                    end
                end
                S_LANE: begin
                    if (lane_done) begin
                        r_state <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    if (cordic_done) begin
                        r_state <= out_free ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.flux_x         = r_flux_x;
    assign o_result.flux_y         = r_flux_y;
    assign o_result.flux_z         = r_flux_z;
    assign o_result.heading_tenths = r_heading;

endmodule

// ===== hw/rtl/mch_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module mch_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input mch_pkg::t_flux    i_flux_x,
    input mch_pkg::t_flux    i_flux_y,
    input mch_pkg::t_flux    i_flux_z,
    input mch_pkg::t_heading i_heading
);
    import mch_pkg::*;

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_flux_x, i_flux_y, i_flux_z, i_heading}))
        else $error("result payload changed while stalled");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_heading <= HEAD_W'(HEAD_MAX)))
        else $error("heading out of range");

    a_on_x_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_flux_y == '0) |->
            (i_heading == (i_flux_x[FLUX_W-1] ? HEAD_W'(HEAD_HALF) : HEAD_W'(0))))
        else $error("heading wrong on x axis");

    a_on_y_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_flux_x == '0) && (i_flux_y != '0) |->
            (i_heading == (i_flux_y[FLUX_W-1] ? HEAD_W'(HEAD_3Q) : HEAD_W'(HEAD_QUARTER))))
        else $error("heading wrong on y axis");

endmodule

bind magnetometer_calibrate_heading mch_checker u_mch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_flux_x    (o_result.flux_x),
    .i_flux_y    (o_result.flux_y),
    .i_flux_z    (o_result.flux_z),
    .i_heading   (o_result.heading_tenths)
);
